/* sv/caq_pkg.sv */
// ----------------------------------------------------------------------------
// caq_pkg
// Shared types, constants and pointer helpers for the CPU affinity request
// queue.
// ----------------------------------------------------------------------------
`default_nettype none

package caq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_CPUS    = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int ID_W        = 22;
  localparam int CNT_W       = 16;
  localparam int MASK_W      = 64;
  localparam int CPU_W       = 6;
  localparam int OCC_W       = 6;
  localparam int OP_W        = 2;
  localparam int STAT_W      = 2;

  localparam logic [ID_W-1:0]  NOBODY    = '0;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_GRANT  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NOTED = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_POP_RD,
    ST_POP_CHK,
    ST_SCAN,
    ST_SKIP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  count;
    logic [MASK_W-1:0] mask;
  } entry_t;

  typedef struct packed {
    ptr_t   rd_addr;
    logic   wr_en;
    ptr_t   wr_addr;
    entry_t wr_data;
    logic   vld_en;
    ptr_t   vld_addr;
    logic   vld_val;
  } store_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  count;
    logic [MASK_W-1:0] mask;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? ptr_t'(QUEUE_DEPTH - 1) : p - ptr_t'(1);
  endfunction

  function automatic logic [OCC_W-1:0] ring_occ(input ptr_t head, input ptr_t tail);
    logic [31:0] d;
    d = 32'(head) - 32'(tail);
    if (head < tail) begin
      d = d + 32'(QUEUE_DEPTH);
    end
    return d[OCC_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/caq_if.sv */
// ----------------------------------------------------------------------------
// caq_req_if / caq_rsp_if
// Request and response channels of the CPU affinity request queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface caq_req_if;
  logic                         valid;
  logic                         ready;
  logic [caq_pkg::OP_W-1:0]     op;
  logic [caq_pkg::ID_W-1:0]     proc_id;
  logic [caq_pkg::CNT_W-1:0]    count;
  logic [caq_pkg::MASK_W-1:0]   allowed_mask;
  logic [caq_pkg::CPU_W-1:0]    cpu_index;

  modport source (output valid, op, proc_id, count, allowed_mask, cpu_index,
                  input ready);
  modport sink   (input valid, op, proc_id, count, allowed_mask, cpu_index,
                  output ready);
endinterface

interface caq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [caq_pkg::STAT_W-1:0]   status;
  logic [caq_pkg::ID_W-1:0]     out_proc_id;
  logic [caq_pkg::CNT_W-1:0]    out_count;
  logic [caq_pkg::MASK_W-1:0]   out_mask;
  logic [caq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_proc_id, out_count, out_mask, occupancy,
                  input ready);
  modport sink   (input valid, status, out_proc_id, out_count, out_mask, occupancy,
                  output ready);
endinterface

`default_nettype wire

/* sv/caq_store.sv */
// ----------------------------------------------------------------------------
// caq_store
// Entry memory with one write and one registered read port, plus a valid
// flag per slot that reset clears at once.
// ----------------------------------------------------------------------------
`default_nettype none

module caq_store (
  input  logic                               clk,
  input  logic                               rst,
  input  caq_pkg::store_cmd_t                cmd,
  output caq_pkg::entry_t                    rd_data,
  output logic [caq_pkg::QUEUE_DEPTH-1:0]    valid
);

  caq_pkg::entry_t mem [caq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    rd_data <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.vld_en) begin
      valid[cmd.vld_addr] <= cmd.vld_val;
    end
  end

endmodule

`default_nettype wire

/* sv/caq_ctrl.sv */
// ----------------------------------------------------------------------------
// caq_ctrl
// Sequencer: runs push, pop, remove and grant against the entry store, scanning
// one slot per cycle through a single compare stage, then advances the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module caq_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  caq_req_if.sink                            req,
  input  caq_pkg::entry_t                    rd_data,
  input  logic [caq_pkg::QUEUE_DEPTH-1:0]    valid,
  input  logic                               out_free,
  output caq_pkg::store_cmd_t                cmd,
  output logic                               done,
  output caq_pkg::result_t                   result
);

  caq_pkg::state_t state, state_next;
  caq_pkg::ptr_t   head, tail, scan_ptr, chk_addr;
  logic            chk_vld;

  caq_pkg::op_t                r_op;
  logic [caq_pkg::ID_W-1:0]    r_id;
  logic [caq_pkg::CNT_W-1:0]   r_cnt;
  logic [caq_pkg::MASK_W-1:0]  r_mask;
  logic [caq_pkg::CPU_W-1:0]   r_cpu;

  caq_pkg::status_t            res_status;
  logic [caq_pkg::ID_W-1:0]    res_id;
  logic [caq_pkg::CNT_W-1:0]   res_count;
  logic [caq_pkg::MASK_W-1:0]  res_mask;

  caq_pkg::op_t                in_op;
  caq_pkg::ptr_t               back;
  logic [caq_pkg::ID_W-1:0]    back_id;
  logic                        back_hit;
  logic                        full;
  logic [caq_pkg::CNT_W:0]     sum;
  logic [caq_pkg::CNT_W-1:0]   sat;
  logic                        issue;
  logic                        chk_live;
  logic                        hit_rm;
  logic                        hit_gr;
  logic                        tail_free;
  logic                        cpu_ok;

  assign in_op     = caq_pkg::op_t'(req.op);
  assign back      = caq_pkg::ptr_dec(head);
  assign back_id   = valid[back] ? rd_data.id : caq_pkg::NOBODY;
  assign back_hit  = (back_id == r_id);
  assign full      = (caq_pkg::ptr_inc(head) == tail);
  assign sum       = {1'b0, rd_data.count} + {1'b0, r_cnt};
  assign sat       = sum[caq_pkg::CNT_W] ? caq_pkg::COUNT_MAX : sum[caq_pkg::CNT_W-1:0];
  assign issue     = (scan_ptr != head);
  assign chk_live  = chk_vld && valid[chk_addr];
  assign hit_rm    = chk_live && (r_op == caq_pkg::OP_REMOVE) && (rd_data.id == r_id);
  assign hit_gr    = chk_live && (r_op == caq_pkg::OP_GRANT) && rd_data.mask[r_cpu];
  assign tail_free = (tail != head) && !valid[tail];
  assign cpu_ok    = (32'(req.cpu_index) < 32'(caq_pkg::NUM_CPUS));

  always_comb begin
    state_next = state;
    case (state)
      caq_pkg::ST_IDLE: begin
        if (req.valid) begin
          case (in_op)
            caq_pkg::OP_PUSH: begin
              if (req.count != '0) begin
                state_next = caq_pkg::ST_PUSH_RD;
              end else if (req.proc_id == caq_pkg::NOBODY) begin
                state_next = caq_pkg::ST_SKIP;
              end else begin
                state_next = caq_pkg::ST_SCAN;
              end
            end
            caq_pkg::OP_REMOVE: begin
              state_next = (req.proc_id == caq_pkg::NOBODY) ? caq_pkg::ST_SKIP
                                                            : caq_pkg::ST_SCAN;
            end
            caq_pkg::OP_POP: state_next = caq_pkg::ST_POP_RD;
            caq_pkg::OP_GRANT: state_next = cpu_ok ? caq_pkg::ST_SCAN : caq_pkg::ST_SKIP;
            default: state_next = caq_pkg::ST_IDLE;
          endcase
        end
      end
      caq_pkg::ST_PUSH_RD: state_next = caq_pkg::ST_PUSH_WR;
      caq_pkg::ST_PUSH_WR: state_next = caq_pkg::ST_SKIP;
      caq_pkg::ST_POP_RD:  state_next = caq_pkg::ST_POP_CHK;
      caq_pkg::ST_POP_CHK: state_next = caq_pkg::ST_SKIP;
      caq_pkg::ST_SCAN: begin
        if (hit_gr || (!issue && !chk_vld)) begin
          state_next = caq_pkg::ST_SKIP;
        end
      end
      caq_pkg::ST_SKIP: begin
        if (!tail_free) begin
          state_next = caq_pkg::ST_DONE;
        end
      end
      caq_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = caq_pkg::ST_IDLE;
        end
      end
      default: state_next = caq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready        = (state == caq_pkg::ST_IDLE);
    done             = (state == caq_pkg::ST_DONE);
    cmd.rd_addr      = scan_ptr;
    cmd.wr_en        = 1'b0;
    cmd.wr_addr      = chk_addr;
    cmd.wr_data      = rd_data;
    cmd.vld_en       = 1'b0;
    cmd.vld_addr     = chk_addr;
    cmd.vld_val      = 1'b0;
    case (state)
      caq_pkg::ST_PUSH_RD: cmd.rd_addr = back;
      caq_pkg::ST_PUSH_WR: begin
        if (back_hit) begin
          cmd.wr_en         = valid[back];
          cmd.wr_addr       = back;
          cmd.wr_data.count = sat;
        end else if (!full) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_addr  = head;
          cmd.wr_data  = '{id: r_id, count: r_cnt, mask: r_mask};
          cmd.vld_en   = 1'b1;
          cmd.vld_addr = head;
          cmd.vld_val  = (r_id != caq_pkg::NOBODY);
        end
      end
      caq_pkg::ST_POP_RD: cmd.rd_addr = tail;
      caq_pkg::ST_POP_CHK: begin
        cmd.vld_en   = valid[tail];
        cmd.vld_addr = tail;
      end
      caq_pkg::ST_SCAN: begin
        if (hit_rm) begin
          cmd.vld_en = 1'b1;
        end else if (hit_gr) begin
          if (rd_data.count <= caq_pkg::CNT_W'(1)) begin
            cmd.vld_en = 1'b1;
          end else begin
            cmd.wr_en         = 1'b1;
            cmd.wr_data.count = rd_data.count - caq_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= caq_pkg::ST_IDLE;
      head    <= '0;
      tail    <= '0;
      chk_vld <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        caq_pkg::ST_IDLE: begin
          chk_vld <= 1'b0;
        end
        caq_pkg::ST_PUSH_WR: begin
          if (!back_hit && !full) begin
            head <= caq_pkg::ptr_inc(head);
          end
        end
        caq_pkg::ST_SCAN: begin
          chk_vld <= issue;
        end
        caq_pkg::ST_SKIP: begin
          if (tail_free) begin
            tail <= caq_pkg::ptr_inc(tail);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      caq_pkg::ST_IDLE: begin
        r_op       <= (in_op == caq_pkg::OP_PUSH && req.count == '0) ? caq_pkg::OP_REMOVE
                                                                     : in_op;
        r_id       <= req.proc_id;
        r_cnt      <= req.count;
        r_mask     <= req.allowed_mask;
        r_cpu      <= req.cpu_index;
        scan_ptr   <= tail;
        chk_addr   <= tail;
        res_status <= caq_pkg::STAT_OK;
        res_id     <= caq_pkg::NOBODY;
        res_count  <= '0;
        res_mask   <= '0;
      end
      caq_pkg::ST_PUSH_WR: begin
        res_status <= (!back_hit && full) ? caq_pkg::STAT_FULL : caq_pkg::STAT_NOTED;
      end
      caq_pkg::ST_POP_CHK: begin
        if (valid[tail]) begin
          res_id    <= rd_data.id;
          res_count <= rd_data.count;
          res_mask  <= rd_data.mask;
        end
      end
      caq_pkg::ST_SCAN: begin
        chk_addr <= scan_ptr;
        if (issue) begin
          scan_ptr <= caq_pkg::ptr_inc(scan_ptr);
        end
        if (hit_gr) begin
          res_id <= rd_data.id;
        end
      end
      default: begin
      end
    endcase
  end

  assign result = '{status:    res_status,
                    id:        res_id,
                    count:     res_count,
                    mask:      res_mask,
                    occupancy: caq_pkg::ring_occ(head, tail)};

endmodule

`default_nettype wire

/* sv/cpu_affinity_request_queue_top.sv */
// ----------------------------------------------------------------------------
// cpu_affinity_request_queue_top
// Ring queue of CPU affinity requests with push, remove, pop and grant.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   op, proc_id, count, allowed_mask, cpu_index
//  rsp      out  status, out_proc_id, out_count, out_mask, occupancy
//
//  Remove and grant scan the queue from the tail, bounded by occupancy,
//  through the single read port of the entry store feeding one compare
//  stage; every request, push and pop too, then advances the tail past
//  each freed slot (up to 63).
//  Reset clears all slot valid flags at once; no clearing pass.
//  A stalled rsp holds its result; the next request is worked meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_affinity_request_queue_top (
  input  logic       clk,
  input  logic       rst,
  caq_req_if.sink    req,
  caq_rsp_if.source  rsp
);

  caq_pkg::store_cmd_t                 cmd;
  caq_pkg::entry_t                     rd_data;
  logic [caq_pkg::QUEUE_DEPTH-1:0]     valid;
  logic                                done;
  logic                                out_free;
  caq_pkg::result_t                    result;

  assign out_free = !rsp.valid || rsp.ready;

  caq_store u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_data (rd_data),
    .valid   (valid)
  );

  caq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_data  (rd_data),
    .valid    (valid),
    .out_free (out_free),
    .cmd      (cmd),
    .done     (done),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (done && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      rsp.status      <= result.status;
      rsp.out_proc_id <= result.id;
      rsp.out_count   <= result.count;
      rsp.out_mask    <= result.mask;
      rsp.occupancy   <= result.occupancy;
    end
  end

endmodule

`default_nettype wire
